>>> hdl/cfp_pkg.sv
// Shared types and constants for the checksummed frame command parser.
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned Channels = 64;

  localparam logic [7:0] StartByte   = 8'h02;
  localparam logic [7:0] EndByte     = 8'h03;
  localparam logic [7:0] StatusOk    = 8'h00;
  localparam logic [7:0] TypeCommand = 8'h64;
  localparam logic [7:0] RecSerial   = 8'h03;
  localparam logic [7:0] RecOutput   = 8'h07;
  localparam logic [7:0] KindMsg     = 8'h0A;

  localparam logic [7:0] CtlByte0 = 8'h03;
  localparam logic [7:0] CtlByte1 = 8'h00;
  localparam logic [7:0] CtlByte2 = 8'h01;
  localparam logic [7:0] CtlByte3 = 8'h00;

  localparam logic [7:0] RateOff  = 8'd0;
  localparam logic [7:0] Rate10Hz = 8'd1;
  localparam logic [7:0] Rate50Hz = 8'd15;
  localparam logic [7:0] Rate100Hz = 8'd16;

  localparam logic [7:0] MinLenHeader = 8'd7;
  localparam logic [7:0] MinLenRecord = 8'd8;
  localparam logic [7:0] MinLenOutput = 8'd14;

  localparam int unsigned NumSlots = 9;
  localparam logic [7:0] SlotPos [NumSlots] = '{
    8'd0, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd9, 8'd11, 8'd13
  };

  typedef enum logic [2:0] {
    CodeNone        = 3'd0,
    CodeOk          = 3'd1,
    CodeBadStatus   = 3'd2,
    CodeBadType     = 3'd3,
    CodeBadEnd      = 3'd4,
    CodeBadSum      = 3'd5,
    CodeShort       = 3'd6,
    CodeUnsupported = 3'd7
  } result_code_e;

  typedef struct packed {
    logic [7:0]   rate_value;
    logic [5:0]   rate_channel;
    logic         rate_written;
    result_code_e result_code;
    logic         ack;
    logic         frame_done;
  } res_t;

  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned TdataW = ((ResW + 7) / 8) * 8;

endpackage

>>> hdl/cfp_parser.sv
// Input register, frame phase machine, checksum and command decode.
`timescale 1ns / 1ps

module cfp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output cfp_pkg::res_t res_o
);

  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhStatus = 3'd1;
  localparam logic [2:0] PhType   = 3'd2;
  localparam logic [2:0] PhLength = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;
  localparam logic [2:0] PhSum    = 3'd5;
  localparam logic [2:0] PhEnd    = 3'd6;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         advance;
  logic [2:0]   phase_q, phase_d;
  logic [7:0]   idx_q, idx_d;
  logic [7:0]   len_q, len_d;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   rsum_q, rsum_d;
  logic [7:0]   cap_q [cfp_pkg::NumSlots];
  cfp_pkg::res_t res, dec;
  logic [7:0]   rate, chan;

  assign advance     = in_valid_q & res_ready_i;
  assign in_ready_o  = ~in_valid_q | res_ready_i;
  assign res_valid_o = in_valid_q;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      idx_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      rsum_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      rsum_q  <= rsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && phase_q == PhData) begin
      for (int k = 0; k < cfp_pkg::NumSlots; k++) begin
        if (idx_q == cfp_pkg::SlotPos[k]) begin
          cap_q[k] <= in_byte_q;
        end
      end
    end
  end

  assign rate = cap_q[7];
  assign chan = cap_q[8];

  always_comb begin
    dec = '0;
    dec.frame_done = 1'b1;
    if (len_q < cfp_pkg::MinLenHeader) begin
      dec.result_code = cfp_pkg::CodeShort;
    end else if (cap_q[1] != cfp_pkg::CtlByte0 || cap_q[2] != cfp_pkg::CtlByte1 ||
                 cap_q[3] != cfp_pkg::CtlByte2 || cap_q[4] != cfp_pkg::CtlByte3) begin
      dec.result_code = cfp_pkg::CodeUnsupported;
    end else if (len_q < cfp_pkg::MinLenRecord) begin
      dec.result_code = cfp_pkg::CodeShort;
    end else if (cap_q[5] == cfp_pkg::RecSerial) begin
      dec.ack         = 1'b1;
      dec.result_code = cfp_pkg::CodeOk;
    end else if (cap_q[5] != cfp_pkg::RecOutput) begin
      dec.result_code = cfp_pkg::CodeUnsupported;
    end else if (len_q < cfp_pkg::MinLenOutput) begin
      dec.result_code = cfp_pkg::CodeShort;
    end else if (cap_q[6] != cfp_pkg::KindMsg) begin
      dec.result_code = cfp_pkg::CodeUnsupported;
    end else if (rate != cfp_pkg::RateOff && rate != cfp_pkg::Rate10Hz &&
                 rate != cfp_pkg::Rate50Hz && rate != cfp_pkg::Rate100Hz) begin
      dec.result_code = cfp_pkg::CodeUnsupported;
    end else if ({1'b0, chan} >= 9'(cfp_pkg::Channels)) begin
      dec.result_code = cfp_pkg::CodeUnsupported;
    end else begin
      dec.ack          = 1'b1;
      dec.result_code  = cfp_pkg::CodeOk;
      dec.rate_written = 1'b1;
      dec.rate_channel = chan[5:0];
      dec.rate_value   = rate;
    end
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    sum_d   = sum_q;
    rsum_d  = rsum_q;
    res     = '0;
    case (phase_q)
      PhStart: begin
        if (in_byte_q == cfp_pkg::StartByte) begin
          idx_d   = '0;
          len_d   = '0;
          sum_d   = '0;
          phase_d = PhStatus;
        end
      end
      PhStatus: begin
        if (in_byte_q != cfp_pkg::StatusOk) begin
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::CodeBadStatus;
          phase_d = PhStart;
          idx_d   = '0;
          len_d   = '0;
        end else begin
          sum_d   = sum_q + in_byte_q;
          phase_d = PhType;
        end
      end
      PhType: begin
        if (in_byte_q != cfp_pkg::TypeCommand) begin
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::CodeBadType;
          phase_d = PhStart;
          idx_d   = '0;
          len_d   = '0;
        end else begin
          sum_d   = sum_q + in_byte_q;
          phase_d = PhLength;
        end
      end
      PhLength: begin
        len_d   = in_byte_q;
        idx_d   = '0;
        sum_d   = sum_q + in_byte_q;
        phase_d = (in_byte_q == 8'd0) ? PhSum : PhData;
      end
      PhData: begin
        sum_d = sum_q + in_byte_q;
        idx_d = idx_q + 8'd1;
        if (idx_d == len_q) begin
          phase_d = PhSum;
        end
      end
      PhSum: begin
        rsum_d  = in_byte_q;
        phase_d = PhEnd;
      end
      PhEnd: begin
        if (in_byte_q != cfp_pkg::EndByte) begin
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::CodeBadEnd;
        end else if (sum_q != rsum_q) begin
          res.frame_done  = 1'b1;
          res.result_code = cfp_pkg::CodeBadSum;
        end else begin
          res = dec;
        end
        phase_d = PhStart;
        idx_d   = '0;
        len_d   = '0;
      end
      default: begin
        phase_d = PhStart;
        idx_d   = '0;
        len_d   = '0;
      end
    endcase
  end

endmodule

>>> hdl/cfp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module cfp_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cfp_pkg::res_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cfp_pkg::res_t data_o
);

  logic          out_valid_q;
  logic          skid_valid_q;
  cfp_pkg::res_t out_q;
  cfp_pkg::res_t skid_q;
  logic          out_free;

  assign ready_o  = ~skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;
  assign out_free = ~out_valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | valid_i;
      skid_valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (valid_i && ready_o) begin
      skid_q <= data_i;
    end
  end

endmodule

>>> hdl/checksummed_frame_command_parser_top.sv
// Top level of the checksummed frame command parser.
`timescale 1ns / 1ps

// Takes one received byte per item and returns exactly one result item per
// byte, in order. Frames are start 0x02, status, type, length, payload,
// checksum, end 0x03; the checksum is the 8-bit sum of status, type, length
// and payload. Results are all zero except on the byte that ends a frame
// attempt, which carries the result code, ack and any rate-table write
// (channel and rate code). A byte is registered on entry, parsed by the
// combinational phase machine and lands in a two-entry output buffer, so the
// block sustains one byte per clock while m_axis_tready stays high; the
// combinational running-sum and decode path sets that rate.
module checksummed_frame_command_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] frame_done, [1] ack, [4:2] result_code, [5] rate_written,
  // [11:6] rate_channel, [19:12] rate_value, rest zero
  output logic [cfp_pkg::TdataW-1:0]  m_axis_tdata
);

  logic          res_valid;
  logic          res_ready;
  cfp_pkg::res_t res;
  cfp_pkg::res_t out_res;

  cfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  cfp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .data_i  (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = cfp_pkg::TdataW'(out_res);

endmodule

>>> hdl/cfp_checker.sv
// Port-level assertions for the checksummed frame command parser.
`timescale 1ns / 1ps

module cfp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [cfp_pkg::TdataW-1:0] m_axis_tdata
);

  cfp_pkg::res_t r;

  assign r = m_axis_tdata[cfp_pkg::ResW-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ack_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.ack |-> r.result_code == cfp_pkg::CodeOk && r.frame_done)
    else $error("ack without ok code");

  a_write_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.rate_written |-> r.ack)
    else $error("rate write without ack");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.frame_done |-> m_axis_tdata == '0)
    else $error("nonzero result outside a frame end");

  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.rate_written |->
      r.rate_value == cfp_pkg::RateOff || r.rate_value == cfp_pkg::Rate10Hz ||
      r.rate_value == cfp_pkg::Rate50Hz || r.rate_value == cfp_pkg::Rate100Hz)
    else $error("illegal rate code written");

endmodule

bind checksummed_frame_command_parser_top cfp_checker u_cfp_checker (.*);

>>> test/checksummed_frame_command_parser_top_tb.sv
// Testbench for the frame command parser: directed frames, then checked random frames.
`timescale 1ns / 1ps

module checksummed_frame_command_parser_top_tb;

  localparam int NumDirected   = 25;
  localparam int RandomItems   = 1250;
  localparam int HoldOffCycles = 150;
  localparam int HoldOffAfter  = 300;
  localparam int DrainCycles   = 10;
  localparam int WatchdogLimit = 2000;

  localparam int PosCtl     = 3;
  localparam int PosRecord  = 7;
  localparam int PosKind    = 9;
  localparam int PosRate    = 11;
  localparam int PosChannel = 13;

  typedef enum logic [2:0] {
    PhStart, PhStatus, PhType, PhLength, PhData, PhSum, PhEnd
  } phase_e;

  typedef enum int {
    ReadyAlways, ReadyMostly, ReadyPeriodic, ReadyRarely
  } ready_mode_e;

  typedef struct packed {
    logic [7:0]            rx;
    logic                  typed;
    cfp_pkg::result_code_e code;
  } stim_row_t;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{8'hFF, 1'b1, cfp_pkg::CodeNone}, '{8'h00, 1'b1, cfp_pkg::CodeNone},
    '{8'h02, 1'b1, cfp_pkg::CodeNone}, '{8'h05, 1'b1, cfp_pkg::CodeBadStatus},
    '{8'h02, 1'b1, cfp_pkg::CodeNone}, '{8'h00, 1'b1, cfp_pkg::CodeNone},
    '{8'h65, 1'b1, cfp_pkg::CodeBadType},
    '{8'h02, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h64, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h64, 1'b0, cfp_pkg::CodeNone}, '{8'h03, 1'b1, cfp_pkg::CodeShort},
    '{8'h02, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h64, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h64, 1'b0, cfp_pkg::CodeNone}, '{8'hFF, 1'b1, cfp_pkg::CodeBadEnd},
    '{8'h02, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h64, 1'b0, cfp_pkg::CodeNone}, '{8'h00, 1'b0, cfp_pkg::CodeNone},
    '{8'h00, 1'b0, cfp_pkg::CodeNone}, '{8'h03, 1'b1, cfp_pkg::CodeBadSum}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [cfp_pkg::TdataW-1:0] m_axis_tdata;

  logic byte_taken;
  logic result_taken;

  stim_row_t     stim_q [$];
  cfp_pkg::res_t expected_parse_q [$];
  int            bytes_in;
  int            results_out;
  int            mismatches;
  int            idle_cycles;

  phase_e     phase_r;
  logic [7:0] len_r;
  logic [7:0] idx_r;
  logic [7:0] sum_r;
  logic [7:0] rx_sum_r;
  logic [7:0] payload_r [256];
  logic [7:0] rate_table [cfp_pkg::Channels];

  checksummed_frame_command_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  assign byte_taken   = s_axis_tvalid && s_axis_tready;
  assign result_taken = m_axis_tvalid && m_axis_tready;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic cfp_pkg::res_t decode_command();
    cfp_pkg::res_t r;
    logic [7:0]    rate;
    logic [7:0]    chan;
    r = '0;
    r.frame_done = 1'b1;
    rate = payload_r[PosRate];
    chan = payload_r[PosChannel];
    if (len_r < cfp_pkg::MinLenHeader) begin
      r.result_code = cfp_pkg::CodeShort;
    end else if (payload_r[PosCtl] != cfp_pkg::CtlByte0 ||
                 payload_r[PosCtl + 1] != cfp_pkg::CtlByte1 ||
                 payload_r[PosCtl + 2] != cfp_pkg::CtlByte2 ||
                 payload_r[PosCtl + 3] != cfp_pkg::CtlByte3) begin
      r.result_code = cfp_pkg::CodeUnsupported;
    end else if (len_r < cfp_pkg::MinLenRecord) begin
      r.result_code = cfp_pkg::CodeShort;
    end else if (payload_r[PosRecord] == cfp_pkg::RecSerial) begin
      r.ack = 1'b1;
      r.result_code = cfp_pkg::CodeOk;
    end else if (payload_r[PosRecord] != cfp_pkg::RecOutput) begin
      r.result_code = cfp_pkg::CodeUnsupported;
    end else if (len_r < cfp_pkg::MinLenOutput) begin
      r.result_code = cfp_pkg::CodeShort;
    end else if (payload_r[PosKind] != cfp_pkg::KindMsg) begin
      r.result_code = cfp_pkg::CodeUnsupported;
    end else if (rate != cfp_pkg::RateOff && rate != cfp_pkg::Rate10Hz &&
                 rate != cfp_pkg::Rate50Hz && rate != cfp_pkg::Rate100Hz) begin
      r.result_code = cfp_pkg::CodeUnsupported;
    end else if (chan >= cfp_pkg::Channels) begin
      r.result_code = cfp_pkg::CodeUnsupported;
    end else begin
      rate_table[chan[5:0]] = rate;
      r.ack = 1'b1;
      r.result_code = cfp_pkg::CodeOk;
      r.rate_written = 1'b1;
      r.rate_channel = chan[5:0];
      r.rate_value = rate;
    end
    return r;
  endfunction

  function automatic cfp_pkg::res_t parse_byte(input logic [7:0] b);
    cfp_pkg::res_t r;
    r = '0;
    case (phase_r)
      PhStart: begin
        if (b == cfp_pkg::StartByte) begin
          idx_r = '0;
          len_r = '0;
          sum_r = '0;
          phase_r = PhStatus;
        end
      end
      PhStatus: begin
        if (b != cfp_pkg::StatusOk) begin
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::CodeBadStatus;
          phase_r = PhStart;
        end else begin
          sum_r = sum_r + b;
          phase_r = PhType;
        end
      end
      PhType: begin
        if (b != cfp_pkg::TypeCommand) begin
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::CodeBadType;
          phase_r = PhStart;
        end else begin
          sum_r = sum_r + b;
          phase_r = PhLength;
        end
      end
      PhLength: begin
        len_r = b;
        idx_r = '0;
        sum_r = sum_r + b;
        phase_r = (b == 8'd0) ? PhSum : PhData;
      end
      PhData: begin
        payload_r[idx_r] = b;
        sum_r = sum_r + b;
        idx_r = idx_r + 8'd1;
        if (idx_r == len_r) phase_r = PhSum;
      end
      PhSum: begin
        rx_sum_r = b;
        phase_r = PhEnd;
      end
      PhEnd: begin
        if (b != cfp_pkg::EndByte) begin
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::CodeBadEnd;
        end else if (sum_r != rx_sum_r) begin
          r.frame_done = 1'b1;
          r.result_code = cfp_pkg::CodeBadSum;
        end else begin
          r = decode_command();
        end
        phase_r = PhStart;
      end
      default: phase_r = PhStart;
    endcase
    return r;
  endfunction

  function automatic void push_rx(input logic [7:0] b);
    stim_q.push_back('{rx: b, typed: 1'b0, code: cfp_pkg::CodeNone});
  endfunction

  task automatic add_random_frame();
    logic [7:0] body [256];
    logic [7:0] st;
    logic [7:0] ty;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] nb;
    int         pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        nb = 8'($urandom);
        if (nb == cfp_pkg::StartByte) nb = nb ^ 8'h01;
        push_rx(nb);
      end
    end
    push_rx(cfp_pkg::StartByte);
    st = cfp_pkg::StatusOk;
    if ($urandom_range(0, 19) == 0) st = 8'($urandom_range(1, 255));
    push_rx(st);
    if (st != cfp_pkg::StatusOk) return;
    ty = cfp_pkg::TypeCommand;
    if ($urandom_range(0, 19) == 0) begin
      ty = 8'($urandom);
      if (ty == cfp_pkg::TypeCommand) ty = ty ^ 8'h01;
    end
    push_rx(ty);
    if (ty != cfp_pkg::TypeCommand) return;

    pick = $urandom_range(0, 99);
    if (pick < 70) len = 8'($urandom_range(14, 20));
    else if (pick < 90) len = 8'($urandom_range(0, 13));
    else if (pick < 98) len = 8'($urandom_range(21, 40));
    else len = 8'($urandom_range(41, 255));
    push_rx(len);

    foreach (body[i]) body[i] = 8'($urandom);
    body[PosCtl]     = cfp_pkg::CtlByte0;
    body[PosCtl + 1] = cfp_pkg::CtlByte1;
    body[PosCtl + 2] = cfp_pkg::CtlByte2;
    body[PosCtl + 3] = cfp_pkg::CtlByte3;
    if ($urandom_range(0, 19) == 0)
      body[PosCtl + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    if (pick < 8) body[PosRecord] = cfp_pkg::RecOutput;
    else if (pick == 8) body[PosRecord] = cfp_pkg::RecSerial;
    if ($urandom_range(0, 9) != 0) body[PosKind] = cfp_pkg::KindMsg;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 3))
        0: body[PosRate] = cfp_pkg::RateOff;
        1: body[PosRate] = cfp_pkg::Rate10Hz;
        2: body[PosRate] = cfp_pkg::Rate50Hz;
        default: body[PosRate] = cfp_pkg::Rate100Hz;
      endcase
    end
    if ($urandom_range(0, 99) < 85)
      body[PosChannel] = 8'($urandom_range(0, cfp_pkg::Channels - 1));

    sum = st + ty + len;
    for (int i = 0; i < len; i++) begin
      push_rx(body[i]);
      sum = sum + body[i];
    end
    if ($urandom_range(0, 19) == 0) sum = sum + 8'($urandom_range(1, 255));
    push_rx(sum);
    nb = cfp_pkg::EndByte;
    if ($urandom_range(0, 19) == 0) begin
      nb = 8'($urandom);
      if (nb == cfp_pkg::EndByte) nb = nb ^ 8'h80;
    end
    push_rx(nb);
  endtask

  task automatic report_mismatch(input string field, input int unsigned got_v,
                                 input int unsigned want_v);
    $display("ERROR result %0d %s: got 0x%0h expected 0x%0h",
             results_out, field, got_v, want_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : byte_mon
    cfp_pkg::res_t want;
    stim_row_t     row;
    if (rst_ni && byte_taken && bytes_in < stim_q.size()) begin
      want = parse_byte(s_axis_tdata);
      row = stim_q[bytes_in];
      if (row.typed) begin
        want = '0;
        if (row.code != cfp_pkg::CodeNone) begin
          want.frame_done = 1'b1;
          want.result_code = row.code;
        end
      end
      expected_parse_q.push_back(want);
      bytes_in++;
    end
  end

  always @(posedge clk_i) begin : result_mon
    cfp_pkg::res_t got;
    cfp_pkg::res_t want;
    if (rst_ni && result_taken) begin
      got = cfp_pkg::res_t'(m_axis_tdata[cfp_pkg::ResW-1:0]);
      if (expected_parse_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 32'd0);
      end else begin
        want = expected_parse_q.pop_front();
        if (got.frame_done !== want.frame_done)
          report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        if (got.ack !== want.ack)
          report_mismatch("ack", 32'(got.ack), 32'(want.ack));
        if (got.result_code !== want.result_code)
          report_mismatch("result_code", 32'(got.result_code), 32'(want.result_code));
        if (got.rate_written !== want.rate_written)
          report_mismatch("rate_written", 32'(got.rate_written), 32'(want.rate_written));
        if (got.rate_channel !== want.rate_channel)
          report_mismatch("rate_channel", 32'(got.rate_channel), 32'(want.rate_channel));
        if (got.rate_value !== want.rate_value)
          report_mismatch("rate_value", 32'(got.rate_value), 32'(want.rate_value));
      end
      results_out++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (byte_taken || result_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("checksummed_frame_command_parser_top_tb failed");
      $finish;
    end
  end

  initial begin : sender
    int idx;
    int burst;
    int gap;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    wait (rst_ni === 1'b1);
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && idx < stim_q.size()) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stim_q[idx].rx;
        do @(posedge clk_i); while (!s_axis_tready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  end

  initial begin : receiver
    int          cyc;
    bit          held;
    ready_mode_e mode;
    m_axis_tready = 1'b0;
    cyc = 0;
    held = 1'b0;
    mode = ReadyAlways;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && results_out >= HoldOffAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end
      if (cyc % 64 == 0) mode = ready_mode_e'($urandom_range(0, 3));
      case (mode)
        ReadyAlways:   m_axis_tready <= 1'b1;
        ReadyMostly:   m_axis_tready <= ($urandom_range(0, 3) != 0);
        ReadyPeriodic: m_axis_tready <= ((cyc % 8) < 5);
        default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      cyc++;
    end
  end

  initial begin : main
    rst_ni = 1'b0;
    bytes_in = 0;
    results_out = 0;
    mismatches = 0;
    idle_cycles = 0;
    phase_r = PhStart;
    len_r = '0;
    idx_r = '0;
    sum_r = '0;
    rx_sum_r = '0;
    foreach (rate_table[i]) rate_table[i] = '0;

    foreach (DirectedRows[i]) stim_q.push_back(DirectedRows[i]);
    while (stim_q.size() < NumDirected + RandomItems) add_random_frame();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_in < stim_q.size()) @(posedge clk_i);
    while (expected_parse_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("checksummed_frame_command_parser_top_tb passed");
    end else begin
      $display("checksummed_frame_command_parser_top_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cfp_pkg.sv
hdl/cfp_parser.sv
hdl/cfp_out_buf.sv
hdl/checksummed_frame_command_parser_top.sv
hdl/cfp_checker.sv
test/checksummed_frame_command_parser_top_tb.sv
